FILE: hw/rtl/scs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg
// Shared codes, widths and constants for the speech sequencer control block.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int OP_W     = 3;
   localparam int DATA_W   = 8;
   localparam int TUNE_W   = 7;
   localparam int VOL_W    = 6;
   localparam int PAUSE_W  = 6;
   localparam int COUNT_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // request operation codes
   localparam logic [OP_W-1:0] OP_LATCH   = 3'd0;
   localparam logic [OP_W-1:0] OP_CONTROL = 3'd1;
   localparam logic [OP_W-1:0] OP_TICK    = 3'd2;
   localparam logic [OP_W-1:0] OP_FINISH  = 3'd3;
   localparam logic [OP_W-1:0] OP_REPLAY  = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_ENABLED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VARIANT_MODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT_LOW     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT_HIGH    = 2'd3;

   // board variants
   localparam logic [1:0] VARIANT_NAR_QUEUE = 2'd0;
   localparam logic [1:0] VARIANT_RESTART   = 2'd2;
   localparam logic [1:0] VARIANT_QUEUE_CH2 = 2'd3;

   localparam logic [PAUSE_W-1:0] NAR_PAUSE_TICKS = 6'd45;
   localparam logic [VOL_W-1:0]   VOL_MAX         = 6'd32;

   typedef struct packed {
      logic                start_play;
      logic [TUNE_W-1:0]   start_tune;
      logic                start_channel;
      logic                replay_started;
      logic                replay_request;
      logic                nar_flag;
      logic                busy_flag;
      logic [VOL_W-1:0]    volume_level;
      logic [COUNT_W-1:0]  atten_count;
   } rsp_type;

endpackage

FILE: hw/rtl/speech_chip_control_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speech_chip_control_sequencer
// Control sequencer of a two-channel speech sample player: latch and control
// port writes, ticks, finish events and replay requests in, one status
// response per request out.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_ready  | op, data, chan
//  rsp_     | out       | rsp_valid/rsp_ready  | play start, replay, status lines
//  csr_     | in        | csr_valid/csr_ready  | index, data (always ready)
//
//  one request per cycle; its response appears in the output register on the
//  following cycle, computed in a single pass from the state registers
//  a request is taken while the output register is empty or being drained
//  reset (synchronous, active high) returns all state to its initial values, sample playback enabled
//  rsp_ready low holds the response and stalls the request side
// ----------------------------------------------------------------------------
module speech_chip_control_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [scs_pkg::OP_W-1:0]       req_op,
   input  logic [scs_pkg::DATA_W-1:0]     req_data,
   input  logic                           req_chan,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_start_play,
   output logic [scs_pkg::TUNE_W-1:0]     rsp_start_tune,
   output logic                           rsp_start_channel,
   output logic                           rsp_replay_started,
   output logic                           rsp_replay_request,
   output logic                           rsp_nar_flag,
   output logic                           rsp_busy_flag,
   output logic [scs_pkg::VOL_W-1:0]      rsp_volume_level,
   output logic [scs_pkg::COUNT_W-1:0]    rsp_atten_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [scs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scs_pkg::CSR_DATA_W-1:0] csr_data
);
   import scs_pkg::*;

   // configuration
   logic                   samples_enabled_ff;
   logic [1:0]             variant_mode_ff;
   logic [2*CSR_DATA_W-1:0] present_ff;

   // state
   logic [DATA_W-1:0]  last_control_ff,   last_control_in;
   logic               start_line_ff,     start_line_in;
   logic               second_line_ff,    second_line_in;
   logic               clock_line_ff,     clock_line_in;
   logic               direction_line_ff, direction_line_in;
   logic [TUNE_W-1:0]  phrase_latch_ff,   phrase_latch_in;
   logic [TUNE_W-1:0]  first_latched_ff,  first_latched_in;
   logic [TUNE_W-1:0]  second_latched_ff, second_latched_in;
   logic [TUNE_W-1:0]  queue0_ff,         queue0_in;
   logic [TUNE_W-1:0]  queue1_ff,         queue1_in;
   logic [1:0]         play_idle_ff,      play_idle_in;
   logic [TUNE_W-1:0]  play_tune0_ff,     play_tune0_in;
   logic [TUNE_W-1:0]  play_tune1_ff,     play_tune1_in;
   logic [PAUSE_W-1:0] pause_count_ff,    pause_count_in;
   logic [VOL_W-1:0]   volume_ff,         volume_in;
   logic [COUNT_W-1:0] pulse_count_ff,    pulse_count_in;
   logic [COUNT_W-1:0] atten_ff,          atten_in;
   logic               nar_ff,            nar_in;
   logic               busy_ff,           busy_in;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic              req_accept;
   logic [DATA_W-1:0] ctrl_diff;
   logic              st_ch, ch2_ch, clk_ch;
   logic              same_playing;
   logic              first_present, second_present;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign ctrl_diff = last_control_ff ^ req_data;
   assign st_ch     = ctrl_diff[0];
   assign ch2_ch    = ctrl_diff[1];
   assign clk_ch    = ctrl_diff[5];

   assign first_present  = present_ff[phrase_latch_ff];
   assign second_present = present_ff[second_latched_ff];

   assign same_playing = (play_idle_ff[0] || play_idle_ff[1])
                       ? (play_idle_ff[0] && play_idle_ff[1])
                       : (play_tune0_ff == play_tune1_ff);

   always_comb begin
      last_control_in   = last_control_ff;
      start_line_in     = start_line_ff;
      second_line_in    = second_line_ff;
      clock_line_in     = clock_line_ff;
      direction_line_in = direction_line_ff;
      phrase_latch_in   = phrase_latch_ff;
      first_latched_in  = first_latched_ff;
      second_latched_in = second_latched_ff;
      queue0_in         = queue0_ff;
      queue1_in         = queue1_ff;
      play_idle_in      = play_idle_ff;
      play_tune0_in     = play_tune0_ff;
      play_tune1_in     = play_tune1_ff;
      pause_count_in    = pause_count_ff;
      volume_in         = volume_ff;
      pulse_count_in    = pulse_count_ff;
      atten_in          = atten_ff;
      nar_in            = nar_ff;
      busy_in           = busy_ff;

      rsp_in                = '0;

      case (req_op)
         OP_LATCH: begin
            phrase_latch_in = req_data[TUNE_W-1:0];
         end
         OP_CONTROL: begin
            if (st_ch) start_line_in = req_data[0];
            if (ch2_ch) second_line_in = req_data[1];
            if (clk_ch) clock_line_in = req_data[5];
            if (ctrl_diff[4]) direction_line_in = req_data[4];

            // volume steps on the falling clk edge
            if (clk_ch && !clock_line_in) begin
               if (direction_line_in) begin
                  if (volume_ff < VOL_MAX) volume_in = volume_ff + VOL_W'(1);
               end else if (volume_ff != '0) begin
                  volume_in = volume_ff - VOL_W'(1);
               end
            end

            // channel 0 start strobe
            if (second_line_in && !ch2_ch && st_ch) begin
               if (!start_line_in) begin
                  first_latched_in = phrase_latch_ff;
                  if (samples_enabled_ff && first_present) begin
                     if (phrase_latch_ff == '0) begin
                        queue0_in = '0;
                        queue1_in = '0;
                     end else begin
                        busy_in = 1'b0;
                     end
                     if (play_idle_ff[0] || phrase_latch_ff == '0 ||
                         variant_mode_ff == VARIANT_RESTART) begin
                        play_idle_in[0]      = 1'b0;
                        play_tune0_in        = phrase_latch_ff;
                        rsp_in.start_play    = 1'b1;
                        rsp_in.start_tune    = phrase_latch_ff;
                        rsp_in.start_channel = 1'b0;
                     end else if (nar_ff) begin
                        queue0_in = phrase_latch_ff;
                        if (variant_mode_ff == VARIANT_NAR_QUEUE) nar_in = 1'b0;
                     end
                  end
               end else if (nar_ff) begin
                  nar_in         = 1'b0;
                  pause_count_in = NAR_PAUSE_TICKS;
               end
            end

            if (!second_line_in && ch2_ch) pulse_count_in = '0;

            // attenuation pulses and channel 1 latch
            if (!second_line_in && st_ch) begin
               if (!start_line_in) begin
                  if (pulse_count_in == '0) second_latched_in = phrase_latch_ff;
               end else begin
                  pulse_count_in = pulse_count_in + COUNT_W'(1);
                  atten_in       = atten_ff + COUNT_W'(1);
                  if (pulse_count_in == COUNT_W'(1)) atten_in = '0;
               end
            end

            // channel 1 start
            if (second_line_in && ch2_ch) begin
               if (samples_enabled_ff && second_present) begin
                  busy_in = 1'b0;
                  if (second_latched_ff == '0) begin
                     queue0_in = '0;
                     queue1_in = '0;
                     busy_in   = 1'b1;
                  end
                  if (play_idle_ff[1] || second_latched_ff == '0 ||
                      variant_mode_ff != VARIANT_QUEUE_CH2) begin
                     play_idle_in[1]      = 1'b0;
                     play_tune1_in        = second_latched_ff;
                     rsp_in.start_play    = 1'b1;
                     rsp_in.start_tune    = second_latched_ff;
                     rsp_in.start_channel = 1'b1;
                  end else begin
                     queue1_in = second_latched_ff;
                  end
               end
            end
            last_control_in = req_data;
         end
         OP_TICK: begin
            if (pause_count_ff != '0) begin
               pause_count_in = pause_count_ff - PAUSE_W'(1);
               if (pause_count_in == '0) nar_in = 1'b1;
            end
         end
         OP_FINISH: begin
            if (req_chan && queue1_ff != '0) rsp_in.replay_request = 1'b1;
            if (!req_chan && (last_control_ff[1:0] == 2'b10 || queue0_ff != '0)) begin
               queue0_in             = first_latched_ff;
               rsp_in.replay_request = 1'b1;
            end
            if (same_playing) play_idle_in[!req_chan] = 1'b1;
            play_idle_in[req_chan] = 1'b1;
            if (play_idle_in[0]) begin
               nar_in = 1'b1;
               if (play_idle_in[1]) busy_in = 1'b1;
            end
         end
         OP_REPLAY: begin
            if (queue0_ff != '0 && samples_enabled_ff) begin
               busy_in               = 1'b0;
               queue0_in             = '0;
               play_idle_in[0]       = 1'b0;
               play_tune0_in         = queue0_ff;
               nar_in                = 1'b0;
               pause_count_in        = NAR_PAUSE_TICKS;
               rsp_in.start_tune     = queue0_ff;
               rsp_in.start_channel  = 1'b0;
               rsp_in.replay_started = 1'b1;
            end else if (queue1_ff != '0 && samples_enabled_ff) begin
               busy_in               = 1'b0;
               queue1_in             = '0;
               play_idle_in[1]       = 1'b0;
               play_tune1_in         = queue1_ff;
               rsp_in.start_tune     = queue1_ff;
               rsp_in.start_channel  = 1'b1;
               rsp_in.replay_started = 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_in.nar_flag     = nar_in;
      rsp_in.busy_flag    = busy_in;
      rsp_in.volume_level = volume_in;
      rsp_in.atten_count  = atten_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_control_ff   <= '0;
         start_line_ff     <= 1'b1;
         second_line_ff    <= 1'b0;
         clock_line_ff     <= 1'b0;
         direction_line_ff <= 1'b0;
         phrase_latch_ff   <= '0;
         first_latched_ff  <= '0;
         second_latched_ff <= '0;
         queue0_ff         <= '0;
         queue1_ff         <= '0;
         play_idle_ff      <= 2'b11;
         play_tune0_ff     <= '0;
         play_tune1_ff     <= '0;
         pause_count_ff    <= '0;
         volume_ff         <= '0;
         pulse_count_ff    <= '0;
         atten_ff          <= '0;
         nar_ff            <= 1'b1;
         busy_ff           <= 1'b1;
      end else if (req_accept) begin
         last_control_ff   <= last_control_in;
         start_line_ff     <= start_line_in;
         second_line_ff    <= second_line_in;
         clock_line_ff     <= clock_line_in;
         direction_line_ff <= direction_line_in;
         phrase_latch_ff   <= phrase_latch_in;
         first_latched_ff  <= first_latched_in;
         second_latched_ff <= second_latched_in;
         queue0_ff         <= queue0_in;
         queue1_ff         <= queue1_in;
         play_idle_ff      <= play_idle_in;
         play_tune0_ff     <= play_tune0_in;
         play_tune1_ff     <= play_tune1_in;
         pause_count_ff    <= pause_count_in;
         volume_ff         <= volume_in;
         pulse_count_ff    <= pulse_count_in;
         atten_ff          <= atten_in;
         nar_ff            <= nar_in;
         busy_ff           <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_enabled_ff <= 1'b1;
         variant_mode_ff    <= '0;
         present_ff         <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLES_ENABLED: samples_enabled_ff <= csr_data[0];
            CSR_VARIANT_MODE:    variant_mode_ff    <= csr_data[1:0];
            CSR_PRESENT_LOW:     present_ff[CSR_DATA_W-1:0] <= csr_data;
            CSR_PRESENT_HIGH:    present_ff[2*CSR_DATA_W-1:CSR_DATA_W] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_start_play     = rsp_ff.start_play;
   assign rsp_start_tune     = rsp_ff.start_tune;
   assign rsp_start_channel  = rsp_ff.start_channel;
   assign rsp_replay_started = rsp_ff.replay_started;
   assign rsp_replay_request = rsp_ff.replay_request;
   assign rsp_nar_flag       = rsp_ff.nar_flag;
   assign rsp_busy_flag      = rsp_ff.busy_flag;
   assign rsp_volume_level   = rsp_ff.volume_level;
   assign rsp_atten_count    = rsp_ff.atten_count;

endmodule

FILE: hw/rtl/scs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks on the speech sequencer control block.
// ----------------------------------------------------------------------------
module scs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_start_play,
   input logic [scs_pkg::TUNE_W-1:0]     rsp_start_tune,
   input logic                           rsp_start_channel,
   input logic                           rsp_replay_started,
   input logic [scs_pkg::VOL_W-1:0]      rsp_volume_level,
   input logic [scs_pkg::COUNT_W-1:0]    rsp_atten_count
);
   import scs_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_volume_level)
                                 && $stable(rsp_atten_count))
      else $error("stalled response changed");

   // volume never leaves its range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_volume_level <= VOL_MAX)
      else $error("volume above maximum");

   // a new play start and a replay never share one response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_start_play && rsp_replay_started))
      else $error("start and replay in one response");

   // phrase and channel are zero when nothing starts
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_start_play && !rsp_replay_started
      |-> rsp_start_tune == '0 && !rsp_start_channel)
      else $error("stray phrase in response");

   // an empty response register always takes requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

endmodule

bind speech_chip_control_sequencer scs_checker u_scs_checker (.*);
